[hdl/ssm_pkg.sv]
// Shared types and constants for the streaming substring matcher.
package ssm_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_PATTERN_DEF   = 16;
	localparam int POSITION_BITS_DEF = 16;

	// Configuration register file layout
	localparam int CFG_BYTES  = 16;
	localparam int LEN_CFG_W  = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;

	// Reported position width
	localparam int OUT_POS_W = 16;

	// Front-to-back queue geometry
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_LENGTH = 2'd0,
		REG_PATTERN_LOW    = 2'd1,
		REG_PATTERN_HIGH   = 2'd2
	} cfg_reg_t;

	// One queued text transaction
	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} qent_t;

endpackage

[hdl/ssm_cfg.sv]
// Pattern registers and the aligned pattern and mask derived from them.
module ssm_cfg #(
	parameter int MAX_PATTERN = ssm_pkg::MAX_PATTERN_DEF,
	parameter int LEN_W       = $clog2(ssm_pkg::MAX_PATTERN_DEF + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [ssm_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic [LEN_W-1:0]                    pat_len,
	output logic [MAX_PATTERN-1:0]              pat_mask,
	output logic [MAX_PATTERN-1:0][7:0]         pat_al
);

	logic [ssm_pkg::LEN_CFG_W-1:0]          len_q;
	logic [ssm_pkg::CFG_DATA_W-1:0]         low_q;
	logic [ssm_pkg::CFG_DATA_W-1:0]         high_q;
	logic [ssm_pkg::CFG_BYTES-1:0][7:0]     pb;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= ssm_pkg::LEN_CFG_W'(1);
			low_q  <= '0;
			high_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				ssm_pkg::REG_PATTERN_LENGTH: len_q  <= cfg_data[ssm_pkg::LEN_CFG_W-1:0];
				ssm_pkg::REG_PATTERN_LOW:    low_q  <= cfg_data;
				ssm_pkg::REG_PATTERN_HIGH:   high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Active length: zero means one, clamp at window depth
	always_comb begin
		if (len_q == '0)
			pat_len = LEN_W'(1);
		else if (int'(len_q) > MAX_PATTERN)
			pat_len = LEN_W'(MAX_PATTERN);
		else
			pat_len = LEN_W'(len_q);
	end

	// Pattern bytes in order, byte 0 first
	always_comb begin
		for (int k = 0; k < ssm_pkg::CFG_BYTES / 2; k++) begin
			pb[k]                          = low_q[8*k +: 8];
			pb[k + ssm_pkg::CFG_BYTES / 2] = high_q[8*k +: 8];
		end
	end

	// Align to the window: slot j (0 = newest) holds pattern byte len-1-j
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			pat_mask[j] = int'(pat_len) > j;
			pat_al[j]   = '0;
			for (int k = 0; k < ssm_pkg::CFG_BYTES; k++) begin
				if (pat_mask[j] && (int'(pat_len) - 1 - j == k))
					pat_al[j] = pb[k];
			end
		end
	end

endmodule

[hdl/ssm_front.sv]
// Input side: accepts text transactions into a short queue for the match engine.
module ssm_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     text_byte,
	input  logic           end_of_text,
	output logic           q_valid,
	output ssm_pkg::qent_t q_entry,
	input  logic           q_pop
);

	ssm_pkg::qent_t                 ent_q [ssm_pkg::Q_DEPTH];
	logic [ssm_pkg::Q_PTR_W-1:0]    wr_ptr_q;
	logic [ssm_pkg::Q_PTR_W-1:0]    rd_ptr_q;
	logic [ssm_pkg::Q_CNT_W-1:0]    count_q;
	logic                           push;

	// Full queue stalls the sender; depends only on registered count
	assign in_stall = count_q == ssm_pkg::Q_CNT_W'(ssm_pkg::Q_DEPTH);
	assign push     = in_valid && !in_stall;
	assign q_valid  = count_q != '0;
	assign q_entry  = ent_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= '{text_byte: text_byte, end_of_text: end_of_text};
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/ssm_back.sv]
// Match engine: byte window, position tracking, compare and result register.
module ssm_back #(
	parameter int MAX_PATTERN   = ssm_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = ssm_pkg::POSITION_BITS_DEF,
	parameter int LEN_W         = $clog2(ssm_pkg::MAX_PATTERN_DEF + 1)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  ssm_pkg::qent_t                      q_entry,
	output logic                                q_pop,
	input  logic [LEN_W-1:0]                    pat_len,
	input  logic [MAX_PATTERN-1:0]              pat_mask,
	input  logic [MAX_PATTERN-1:0][7:0]         pat_al,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                match_hit,
	output logic [ssm_pkg::OUT_POS_W-1:0]       match_start,
	output logic [ssm_pkg::OUT_POS_W-1:0]       match_end,
	output logic                                text_done,
	output logic                                found_any,
	output logic                                position_overflow
);

	localparam int EXT_W = (POSITION_BITS > ssm_pkg::OUT_POS_W) ?
		POSITION_BITS : ssm_pkg::OUT_POS_W;

	logic [MAX_PATTERN-1:0][7:0]    win_q;
	logic [POSITION_BITS-1:0]       pos_q;
	logic                           any_q;
	logic                           ovf_q;
	logic                           out_valid_q;

	logic [MAX_PATTERN-1:0][7:0]    win_n;
	logic [POSITION_BITS-1:0]       pos_n;
	logic [POSITION_BITS-1:0]       len_p;
	logic [POSITION_BITS-1:0]       start_p;
	logic [EXT_W-1:0]               start_x;
	logic [EXT_W-1:0]               end_x;
	logic                           sat;
	logic                           hit;

	// Advance when a transaction waits and the result slot is free
	assign q_pop     = q_valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	// Shifted window, newest byte in slot 0
	always_comb begin
		win_n[0] = q_entry.text_byte;
		for (int j = 1; j < MAX_PATTERN; j++)
			win_n[j] = win_q[j-1];
	end

	// Saturating position
	assign sat   = pos_q == '1;
	assign pos_n = sat ? pos_q : pos_q + 1'b1;
	assign len_p = POSITION_BITS'(pat_len);

	// Parallel compare over the active slots
	always_comb begin
		hit = pos_n >= len_p;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			if (pat_mask[j] && (win_n[j] != pat_al[j]))
				hit = 1'b0;
		end
	end

	assign start_p = pos_n - len_p + POSITION_BITS'(1);
	assign start_x = EXT_W'(start_p);
	assign end_x   = EXT_W'(pos_n);

	// Per-text state; cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			pos_q <= '0;
			any_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (q_pop) begin
			if (q_entry.end_of_text) begin
				win_q <= '0;
				pos_q <= '0;
				any_q <= 1'b0;
				ovf_q <= 1'b0;
			end else begin
				win_q <= win_n;
				pos_q <= pos_n;
				any_q <= any_q | hit;
				ovf_q <= ovf_q | sat;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (q_pop)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (q_pop) begin
			match_hit         <= hit;
			match_start       <= hit ? start_x[ssm_pkg::OUT_POS_W-1:0] : '0;
			match_end         <= hit ? end_x[ssm_pkg::OUT_POS_W-1:0] : '0;
			text_done         <= q_entry.end_of_text;
			found_any         <= q_entry.end_of_text && (any_q || hit);
			position_overflow <= ovf_q || sat;
		end
	end

endmodule

[hdl/substring_match_stream.sv]
// Top level of the streaming substring matcher.
//
// Text bytes enter on the in channel (in_valid / in_stall, text_byte,
// end_of_text), one transaction per byte. Every byte produces exactly one
// result on the out channel (out_valid / out_stall): match_hit with the
// 1-based match_start and match_end when the pattern ends at that byte.
// The byte flagged end_of_text returns text_done and found_any, then the
// window, position counter and flags clear for the next text.
// The pattern (1 to 16 bytes) is set through cfg_write / cfg_index / cfg_data
// between texts; register 0 is the length, 1 and 2 hold the bytes.
// A byte is written into the queue when it is accepted, then moves into the
// result register once the result slot is free.
// One byte per cycle is sustained while out_stall is low, using a parallel
// window compare. A two-entry queue separates the input side from the match engine,
// and the result register holds while out_stall is high; once the queue
// fills, in_stall rises. Reset sets the length to one, clears the pattern and
// empties the queue and result register.
module substring_match_stream #(
	parameter int MAX_PATTERN   = ssm_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = ssm_pkg::POSITION_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write,
	input  logic [ssm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ssm_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      text_byte,
	input  logic                            end_of_text,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            match_hit,
	output logic [ssm_pkg::OUT_POS_W-1:0]   match_start,
	output logic [ssm_pkg::OUT_POS_W-1:0]   match_end,
	output logic                            text_done,
	output logic                            found_any,
	output logic                            position_overflow
);

	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	logic [LEN_W-1:0]               pat_len;
	logic [MAX_PATTERN-1:0]         pat_mask;
	logic [MAX_PATTERN-1:0][7:0]    pat_al;
	logic                           q_valid;
	logic                           q_pop;
	ssm_pkg::qent_t                 q_entry;

	ssm_cfg #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_W       (LEN_W)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pat_len   (pat_len),
		.pat_mask  (pat_mask),
		.pat_al    (pat_al)
	);

	ssm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.q_valid     (q_valid),
		.q_entry     (q_entry),
		.q_pop       (q_pop)
	);

	ssm_back #(
		.MAX_PATTERN   (MAX_PATTERN),
		.POSITION_BITS (POSITION_BITS),
		.LEN_W         (LEN_W)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_entry           (q_entry),
		.q_pop             (q_pop),
		.pat_len           (pat_len),
		.pat_mask          (pat_mask),
		.pat_al            (pat_al),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.match_hit         (match_hit),
		.match_start       (match_start),
		.match_end         (match_end),
		.text_done         (text_done),
		.found_any         (found_any),
		.position_overflow (position_overflow)
	);

endmodule

[hdl/ssm_checker.sv]
// Port-level checks for the substring matcher, bound to the top level.
module ssm_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            match_hit,
	input logic [ssm_pkg::OUT_POS_W-1:0]   match_start,
	input logic [ssm_pkg::OUT_POS_W-1:0]   match_end,
	input logic                            text_done,
	input logic                            found_any,
	input logic                            position_overflow
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(match_hit) && $stable(match_start) &&
			$stable(match_end) && $stable(text_done) && $stable(found_any) &&
			$stable(position_overflow))
		else $error("result payload changed while stalled");

	// No match means zero positions
	a_no_hit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !match_hit |-> match_start == '0 && match_end == '0)
		else $error("positions reported without a match");

	// found_any only on the closing result, and implied by a hit there
	a_found_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (found_any || (text_done && match_hit)) |-> text_done && found_any)
		else $error("found_any inconsistent with text_done and match_hit");

endmodule

bind substring_match_stream ssm_checker u_ssm_checker (.*);
